### hw/rtl/iasp_pkg.sv
`default_nettype none

package iasp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_UNCLOSED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_SIGN,
    OP_PUSH,
    OP_POP,
    OP_FOLD
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [DIGIT_W-1:0]  digit;
    logic                minus;
    logic                last;
    status_e             status;
  } ctl_t;

endpackage

`default_nettype wire

### hw/rtl/iasp_in_if.sv
`default_nettype none

interface iasp_in_if;
  import iasp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

### hw/rtl/iasp_out_if.sv
`default_nettype none

interface iasp_out_if;
  import iasp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] value;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/iasp_front.sv
`default_nettype none

module iasp_front #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned AW = 4,
  parameter int unsigned DW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  iasp_in_if.sink            in_i,
  input  wire logic          exec_go_i,
  output iasp_pkg::ctl_t     ctl_o,
  output logic               p_valid_o,
  output logic [AW-1:0]      push_idx_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o
);
  import iasp_pkg::*;

  logic          p_valid_q;
  ctl_t          ctl_q, ctl_d;
  logic [AW-1:0] idx_q;
  logic [DW-1:0] depth_q, depth_d;
  status_e       err_q, err_d, err_n;
  logic          acc;
  logic          ovf, unm;

  assign in_i.ready = !p_valid_q || exec_go_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    ctl_d         = '0;
    ctl_d.op      = OP_NONE;
    ctl_d.digit   = DIGIT_W'(in_i.char_code - CH_0);
    ctl_d.minus   = (in_i.char_code == CH_MINUS);
    ctl_d.last    = in_i.last_char;
    ctl_d.status  = ST_OK;
    depth_d       = depth_q;
    ovf           = 1'b0;
    unm           = 1'b0;
    rd_en_o       = 1'b0;
    rd_addr_o     = AW'(depth_q - 1'b1);
    unique case (in_i.char_code) inside
      [CH_0:CH_9]:       ctl_d.op = OP_DIGIT;
      CH_PLUS, CH_MINUS: ctl_d.op = OP_SIGN;
      CH_OPEN: begin
        if (depth_q == DW'(STACK_DEPTH)) begin
          ovf = 1'b1;
        end else begin
          ctl_d.op = OP_PUSH;
          depth_d  = depth_q + 1'b1;
        end
      end
      CH_CLOSE: begin
        if (depth_q == '0) begin
          unm      = 1'b1;
          ctl_d.op = OP_FOLD;
        end else begin
          ctl_d.op = OP_POP;
          depth_d  = depth_q - 1'b1;
          rd_en_o  = acc;
        end
      end
      default: ctl_d.op = OP_NONE;
    endcase

    err_n = err_q;
    if (err_n == ST_OK && ovf) err_n = ST_OVERFLOW;
    if (err_n == ST_OK && unm) err_n = ST_UNMATCHED;
    ctl_d.status = err_n;
    if (err_n == ST_OK && depth_d != '0) ctl_d.status = ST_UNCLOSED;
    err_d = err_n;
    if (in_i.last_char) begin
      err_d   = ST_OK;
      depth_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      depth_q   <= '0;
      err_q     <= ST_OK;
    end else begin
      if (acc) begin
        p_valid_q <= 1'b1;
        depth_q   <= depth_d;
        err_q     <= err_d;
      end else if (exec_go_i) begin
        p_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      ctl_q <= ctl_d;
      idx_q <= depth_q[AW-1:0];
    end
  end

  assign ctl_o      = ctl_q;
  assign p_valid_o  = p_valid_q;
  assign push_idx_o = idx_q;

endmodule

`default_nettype wire

### hw/rtl/iasp_exec.sv
`default_nettype none

module iasp_exec #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned AW = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire iasp_pkg::ctl_t  ctl_i,
  input  wire logic            p_valid_i,
  input  wire logic [AW-1:0]   push_idx_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output logic                 exec_go_o,
  iasp_out_if.source           out_o
);
  import iasp_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned EW = (VW > OUT_W) ? VW : OUT_W;

  logic [VW:0]   mem [STACK_DEPTH];
  logic [VW:0]   rd_q, fwd_data_q, saved, wdata;
  logic          fwd_q, we;

  logic [VW-1:0] sum_q, sum_d, num_q, num_d, term;
  logic          neg_q, neg_d;
  logic [VW-1:0] ss, sa, na;
  logic          pn, tn;

  logic          oval_q;
  logic [VW-1:0] fin_sum_q, fin_num_q, fin_val;
  logic          fin_neg_q;
  status_e       fin_st_q;
  logic [EW-1:0] fin_ext;

  assign exec_go_o = p_valid_i && !(ctl_i.last && oval_q && !out_o.ready);
  assign we        = exec_go_o && (ctl_i.op == OP_PUSH);
  assign wdata     = {neg_q, sum_q};

  always_ff @(posedge clk_i) begin
    if (we) mem[push_idx_i] <= wdata;
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= we && (push_idx_i == rd_addr_i);
    end
  end

  assign saved = fwd_q ? fwd_data_q : rd_q;
  assign pn    = saved[VW];
  assign ss    = saved[VW-1:0];
  assign tn    = neg_q ^ pn;
  assign sa    = pn ? ~sum_q : sum_q;
  assign na    = tn ? ~num_q : num_q;
  assign term  = neg_q ? (VW'(0) - num_q) : num_q;

  always_comb begin
    sum_d = sum_q;
    num_d = num_q;
    neg_d = neg_q;
    case (ctl_i.op)
      OP_DIGIT: num_d = {num_q[VW-4:0], 3'b000} + {num_q[VW-2:0], 1'b0} + VW'(ctl_i.digit);
      OP_SIGN: begin
        sum_d = sum_q + term;
        num_d = '0;
        neg_d = ctl_i.minus;
      end
      OP_PUSH: begin
        sum_d = '0;
        neg_d = 1'b0;
      end
      OP_POP: begin
        sum_d = ss + sa + na + VW'(pn) + VW'(tn);
        num_d = '0;
      end
      OP_FOLD: begin
        sum_d = sum_q + term;
        num_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      num_q  <= '0;
      neg_q  <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      if (exec_go_o && ctl_i.last) begin
        oval_q <= 1'b1;
      end else if (out_o.ready) begin
        oval_q <= 1'b0;
      end
      if (exec_go_o) begin
        if (ctl_i.last) begin
          sum_q  <= '0;
          num_q  <= '0;
          neg_q  <= 1'b0;
        end else begin
          sum_q <= sum_d;
          num_q <= num_d;
          neg_q <= neg_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go_o && ctl_i.last) begin
      fin_sum_q <= sum_d;
      fin_num_q <= num_d;
      fin_neg_q <= neg_d;
      fin_st_q  <= ctl_i.status;
    end
  end

  // final fold of the pending number
  assign fin_val = fin_sum_q + (fin_neg_q ? (VW'(0) - fin_num_q) : fin_num_q);
  assign fin_ext = EW'(fin_val);

  assign out_o.valid  = oval_q;
  assign out_o.value  = fin_ext[OUT_W-1:0];
  assign out_o.status = fin_st_q;

endmodule

`default_nettype wire

### hw/rtl/infix_add_sub_paren_evaluator.sv
`default_nettype none

// channel  dir  words                 fields
// in_i     in   one char per word     char_code[7:0], last_char
// out_o    out  one per expression    value[31:0] signed, status[1:0]
//
// One char per cycle unless stalled. Decode stage tracks depth and errors
// and issues the stack read; execute stage updates sum/number and writes
// the stack (single-port-write RAM, clocked read, write-to-read forwarding).
// Result is registered by the execute stage from the last character.
// Input stalls only while a last character waits behind an untaken result.
// Reset clears control state; the stack needs no clearing pass.

module infix_add_sub_paren_evaluator #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iasp_in_if.sink    in_i,
  iasp_out_if.source out_o
);
  import iasp_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  ctl_t          ctl;
  logic          p_valid;
  logic [AW-1:0] push_idx;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          exec_go;

  iasp_front #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW),
    .DW          (DW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .exec_go_i  (exec_go),
    .ctl_o      (ctl),
    .p_valid_o  (p_valid),
    .push_idx_o (push_idx),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  iasp_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .p_valid_i  (p_valid),
    .push_idx_i (push_idx),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .exec_go_o  (exec_go),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

### verif/infix_add_sub_paren_evaluator_test.sv
`default_nettype none

module infix_add_sub_paren_evaluator_test;
  import iasp_pkg::*;

  localparam int unsigned STACK_LEVELS = 16;
  localparam int unsigned RANDOM_CHARS = 200;

  typedef struct {
    logic [OUT_W-1:0] value;
    status_e          status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  iasp_in_if  in_if ();
  iasp_out_if out_if ();

  infix_add_sub_paren_evaluator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // evaluator state as seen by the testbench
  logic [OUT_W-1:0] acc;
  logic [OUT_W-1:0] num;
  logic             neg;
  logic [OUT_W-1:0] lvl_sum [STACK_LEVELS];
  logic             lvl_neg [STACK_LEVELS];
  int unsigned      depth;
  status_e          err;

  result_t results_due[$];
  int      mismatches = 0;
  int      chars_sent = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  task automatic clear_state();
    acc   = '0;
    num   = '0;
    neg   = 1'b0;
    depth = 0;
    err   = ST_OK;
  endtask

  task automatic fold_number();
    acc = acc + (neg ? -num : num);
    num = '0;
  endtask

  task automatic flag_error(input status_e code);
    if (err == ST_OK) err = code;
  endtask

  task automatic evaluate_char(input logic [CHAR_W-1:0] c, input logic last);
    result_t r;
    if (c >= CH_0 && c <= CH_9) begin
      num = num * 10 + OUT_W'(c - CH_0);
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      fold_number();
      neg = (c == CH_MINUS);
    end else if (c == CH_OPEN) begin
      if (depth >= STACK_LEVELS) begin
        flag_error(ST_OVERFLOW);
      end else begin
        lvl_sum[depth] = acc;
        lvl_neg[depth] = neg;
        depth++;
        acc = '0;
        neg = 1'b0;
      end
    end else if (c == CH_CLOSE) begin
      fold_number();
      if (depth == 0) begin
        flag_error(ST_UNMATCHED);
      end else begin
        depth--;
        if (lvl_neg[depth]) acc = -acc;
        acc = acc + lvl_sum[depth];
      end
    end
    if (last) begin
      fold_number();
      if (depth != 0) flag_error(ST_UNCLOSED);
      r.value  = acc;
      r.status = err;
      results_due.push_back(r);
      clear_state();
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // word monitor: check results, then predict from accepted characters
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result value %0d status %0d",
                                  $signed(out_if.value), out_if.status));
        end else begin
          r = results_due.pop_front();
          if (out_if.value !== r.value)
            note_mismatch($sformatf("value expected %0d actual %0d",
                                    $signed(r.value), $signed(out_if.value)));
          if (out_if.status !== r.status)
            note_mismatch($sformatf("status expected %0d actual %0d",
                                    r.status, out_if.status));
        end
      end
      if (in_if.valid && in_if.ready) evaluate_char(in_if.char_code, in_if.last_char);
    end
  end

  // result receiver; a requested hold-off is counted here
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 250;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= 13);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while (!quiet && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.last_char <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_expr(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic string rand_number();
    string s;
    int    n;
    s = "";
    n = ($urandom_range(7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
    if ($urandom_range(9) == 0) begin
      repeat (n) s = {s, "9"};
    end else begin
      repeat (n) s = $sformatf("%s%0d", s, $urandom_range(9));
    end
    return s;
  endfunction

  function automatic string make_expr(input bit broken);
    string s;
    int    lvl;
    int    n;
    bit    want_operand;
    s = "";
    lvl = 0;
    want_operand = 1'b1;
    n = $urandom_range(1, 14);
    if (broken && $urandom_range(2) == 0) repeat (STACK_LEVELS + 1) s = {s, "("};
    if ($urandom_range(3) == 0) s = {s, "-"};
    for (int i = 0; i < n; i++) begin
      if (want_operand) begin
        if (lvl < STACK_LEVELS && $urandom_range(2) == 0) begin
          s = {s, "("};
          lvl++;
          if ($urandom_range(3) == 0) s = {s, "-"};
        end else begin
          s = {s, rand_number()};
          want_operand = 1'b0;
        end
      end else if (lvl > 0 && $urandom_range(2) == 0) begin
        s = {s, ")"};
        lvl--;
      end else begin
        s = {s, ($urandom_range(1) == 0) ? "+" : "-"};
        want_operand = 1'b1;
      end
      if ($urandom_range(15) == 0) s = {s, " "};
    end
    if (want_operand) s = {s, rand_number()};
    if (!broken) begin
      repeat (lvl) s = {s, ")"};
    end else begin
      case ($urandom_range(2))
        0: s = {s, ")"};
        1: s = {")", s};
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic test_directed();
    send_expr("0");
    send_expr("2147483647+1");
    send_expr("4294967296-1");
    send_expr("1+2-3- 10");
    send_expr("-(5+(2-7))");
    send_expr("12(3)4");
    send_expr("(1-)2");
    send_expr(")7");
    send_expr("((3");
    send_expr(")(");
    send_expr("(((((((((((((((((1)))))))))))))))");
    send_expr("a\t9z+");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_noise();
    repeat (60) send_char(CHAR_W'($urandom), ($urandom_range(7) == 0));
    send_char(CH_0, 1'b1);
  endtask

  task automatic test_random_exprs();
    int start;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      if ($urandom_range(19) == 0) send_char(CHAR_W'($urandom), 1'b0);
      send_expr(make_expr($urandom_range(4) == 0));
    end
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    repeat (10) send_expr(make_expr(1'b0));
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    string s;
    hold_req = 1'b1;
    repeat (25) begin
      s = make_expr(1'b0);
      send_expr(s.substr(0, 0));
    end
    repeat (10) send_expr("1+2");
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    in_if.last_char = 1'b0;
    clear_state();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_noise();
    test_random_exprs();
    test_no_idle();
    test_backpressure();

    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/iasp_pkg.sv
hw/rtl/iasp_in_if.sv
hw/rtl/iasp_out_if.sv
hw/rtl/iasp_front.sv
hw/rtl/iasp_exec.sv
hw/rtl/infix_add_sub_paren_evaluator.sv
verif/infix_add_sub_paren_evaluator_test.sv
